### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### design/rrip_pkg.sv
`timescale 1ns / 1ps

package rrip_pkg;

    localparam int NUM_SETS_DEF    = 2048;
    localparam int NUM_WAYS_DEF    = 16;
    localparam int LEADER_SETS_DEF = 32;

    localparam logic [1:0] RRV_MAX    = 2'd3;
    localparam logic [9:0] SEL_MAX    = 10'd1023;
    localparam logic [9:0] SEL_MID    = 10'd512;
    localparam logic [6:0] NEAR_RESET = 7'd5;
    localparam logic [15:0] DECAY_RESET = 16'd4096;

    localparam logic CFG_NEAR  = 1'b0;
    localparam logic CFG_DECAY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT,
        ST_DECAY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;      // write reset values into the row at the sweep address
        logic dec_en;      // read for the decay sweep
        logic sweep_step;  // advance the sweep address
        logic sweep_start; // restart the sweep address
        logic load;        // capture the request
        logic rd;          // read the request row
        logic exec;        // compute and write back
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic decay_due;
    } t_status;

endpackage

### design/rrip_ram.sv
`timescale 1ns / 1ps

module rrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/rrip_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrip_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rrip_pkg::t_status i_status,
    output rrip_pkg::t_cmd    o_cmd
);
    import rrip_pkg::*;

    t_state r_state, n_state;
    logic   r_dec_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_dec_wr <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dec_wr <= (r_state == ST_DECAY) && !r_dec_wr;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (i_status.sweep_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = i_status.decay_due ? ST_DECAY : ST_OUT;
            ST_DECAY: if (r_dec_wr && i_status.sweep_done) n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // The decay sweep alternates a read and a write of each row.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en     = 1'b1;
                o_cmd.sweep_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
            end
            ST_READ: o_cmd.rd = 1'b1;
            ST_EXEC: begin
                o_cmd.exec        = 1'b1;
                o_cmd.sweep_start = 1'b1;
            end
            ST_DECAY: begin
                o_cmd.dec_en     = !r_dec_wr;
                o_cmd.sweep_step = r_dec_wr;
            end
            ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    `ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE, "ready outside idle")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready, "ready with pending result")

endmodule

### design/rrip_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrip_dp #(
    parameter int NUM_SETS    = rrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = rrip_pkg::NUM_WAYS_DEF,
    parameter int LEADER_SETS = rrip_pkg::LEADER_SETS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrip_pkg::t_cmd    i_cmd,
    output rrip_pkg::t_status o_status,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_mode,
    input  logic [10:0]       i_set_index,
    input  logic [3:0]        i_way_index,
    input  logic              i_was_hit,
    input  logic [15:0]       i_valid_mask,
    input  logic [6:0]        i_random_draw,
    output logic [3:0]        o_victim_way,
    output logic [9:0]        o_selector_value
);
    import rrip_pkg::*;

    localparam int SW = $clog2(NUM_SETS);
    localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RW = 2 * NUM_WAYS;

    logic [6:0]  r_near;
    logic [15:0] r_decay;
    logic [15:0] r_upd_cnt;
    logic [9:0]  r_sel;
    logic [3:0]  r_victim;
    logic        r_mode, r_hit;
    logic [SW-1:0] r_set;
    logic [4:0]  r_way;
    logic [15:0] r_mask;
    logic [6:0]  r_draw;
    logic [SW-1:0] r_sweep;
    logic        r_sweep_last;
    logic        r_due;

    logic [RW-1:0] rrv_rd, ctr_rd;
    logic [RW-1:0] rrv_wd, ctr_wd;
    logic          rrv_we, ctr_we;
    logic [SW-1:0] waddr, raddr;

    logic [RW-1:0] n_rrv_row, n_ctr_row;
    logic [3:0]    n_victim;
    logic [9:0]    n_sel;
    logic [1:0]    top;
    logic [1:0]    add;
    logic          found;
    logic          way_ok;
    logic [1:0]    old_ctr, low_ctr;
    logic          drrip_l, lip_l, use_lip;
    logic [16:0]   cnt_inc;
    logic [15:0]   per;
    logic [RW-1:0] dec_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near    <= NEAR_RESET;
            r_decay   <= DECAY_RESET;
            r_upd_cnt <= '0;
            r_sel     <= SEL_MID;
            r_sweep   <= '0;
            r_due     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_NEAR) r_near <= i_cfg_data[6:0];
                else r_decay <= i_cfg_data;
            end
            if (i_cmd.sweep_start) r_sweep <= '0;
            else if (i_cmd.sweep_step) r_sweep <= r_sweep + SW'(1);
            // A victim request never starts a sweep.
            if (i_cmd.rd) begin
                r_due <= r_mode && (cnt_inc[15:0] >= per);
                if (r_mode) begin
                    r_upd_cnt <= (cnt_inc[15:0] >= per) ? 16'd0 : cnt_inc[15:0];
                end
            end
            if (i_cmd.exec) r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_set  <= SW'(i_set_index);
            r_way  <= {1'b0, i_way_index};
            r_hit  <= i_was_hit;
            r_mask <= i_valid_mask;
            r_draw <= i_random_draw;
        end
        if (i_cmd.exec) r_victim <= n_victim;
        r_sweep_last <= (r_sweep == SW'(NUM_SETS - 1));
    end

    assign cnt_inc = {1'b0, r_upd_cnt} + 17'd1;
    assign per     = (r_decay == 16'd0) ? 16'd1 : r_decay;

    assign raddr = (i_cmd.rd) ? r_set : r_sweep;
    assign waddr = (i_cmd.exec) ? r_set : r_sweep;

    // Leader set decode.
    assign drrip_l = (32'(r_set) < LEADER_SETS);
    assign lip_l   = (32'(r_set) >= NUM_SETS / 2) && (32'(r_set) < NUM_SETS / 2 + LEADER_SETS);
    assign use_lip = drrip_l ? 1'b0 : (lip_l ? 1'b1 : (r_sel < SEL_MID));
    assign way_ok  = (32'(r_way) < NUM_WAYS);
    assign old_ctr = ctr_rd[2*r_way[WW-1:0] +: 2];
    assign low_ctr = (old_ctr != 2'd0) ? old_ctr - 2'd1 : 2'd0;

    always_comb begin
        n_rrv_row = rrv_rd;
        n_ctr_row = ctr_rd;
        n_sel     = r_sel;
        n_victim  = '0;
        top       = '0;
        add       = '0;
        found     = 1'b0;
        if (!r_mode) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!found && (w >= 16 || !r_mask[w % 16])) begin
                    found    = 1'b1;
                    n_victim = 4'(w);
                end
            end
            if (!found) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (rrv_rd[2*w +: 2] > top) top = rrv_rd[2*w +: 2];
                end
                add = RRV_MAX - top;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    n_rrv_row[2*w +: 2] = rrv_rd[2*w +: 2] + add;
                end
                for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                    if (n_rrv_row[2*w +: 2] == RRV_MAX) n_victim = 4'(w);
                end
            end
        end else if (way_ok) begin
            if (r_hit) begin
                n_ctr_row[2*r_way[WW-1:0] +: 2] = (old_ctr != 2'd3) ? old_ctr + 2'd1 : old_ctr;
                n_rrv_row[2*r_way[WW-1:0] +: 2] = 2'd0;
                if (drrip_l) begin
                    if (r_sel != SEL_MAX) n_sel = r_sel + 10'd1;
                end else if (lip_l) begin
                    if (r_sel != 10'd0) n_sel = r_sel - 10'd1;
                end
            end else begin
                n_ctr_row[2*r_way[WW-1:0] +: 2] = 2'd1;
                if (low_ctr >= 2'd2) n_rrv_row[2*r_way[WW-1:0] +: 2] = 2'd0;
                else if (use_lip) n_rrv_row[2*r_way[WW-1:0] +: 2] = RRV_MAX;
                else n_rrv_row[2*r_way[WW-1:0] +: 2] = (r_draw < r_near) ? 2'd1 : 2'd2;
            end
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            dec_row[2*w +: 2] = (ctr_rd[2*w +: 2] != 2'd0) ? ctr_rd[2*w +: 2] - 2'd1 : 2'd0;
        end
    end

    always_comb begin
        rrv_we = 1'b0;
        ctr_we = 1'b0;
        rrv_wd = n_rrv_row;
        ctr_wd = n_ctr_row;
        if (i_cmd.clr_en) begin
            rrv_we = 1'b1;
            ctr_we = 1'b1;
            rrv_wd = {NUM_WAYS{RRV_MAX}};
            ctr_wd = {NUM_WAYS{2'd1}};
        end else if (i_cmd.exec) begin
            rrv_we = 1'b1;
            ctr_we = 1'b1;
        end else if (i_cmd.sweep_step) begin
            ctr_we = 1'b1;
            ctr_wd = dec_row;
        end
    end

    rrip_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_rrv (
        .i_clk(i_clk), .i_we(rrv_we), .i_waddr(waddr), .i_wdata(rrv_wd),
        .i_raddr(raddr), .o_rdata(rrv_rd)
    );

    rrip_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_ctr (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(waddr), .i_wdata(ctr_wd),
        .i_raddr(raddr), .o_rdata(ctr_rd)
    );

    assign o_status.sweep_done = (r_sweep == SW'(NUM_SETS - 1));
    assign o_status.decay_due  = r_due;
    assign o_victim_way        = r_victim;
    assign o_selector_value    = r_sel;

    `ASSERT_NEXT(a_sel_step, i_clk, i_rst_n, i_cmd.exec, (r_sel - $past(r_sel) == 10'd1) || (r_sel == $past(r_sel)) || ($past(r_sel) - r_sel == 10'd1), "selector jumped")
    `ASSERT_IMP(a_upd_victim, i_clk, i_rst_n, i_cmd.exec && r_mode, n_victim == 4'd0, "update gave a victim")
    `ASSERT_NEXT(a_sweep_wrap, i_clk, i_rst_n, i_cmd.sweep_step && r_sweep_last, r_sweep == '0, "sweep did not wrap")

endmodule

### design/rrip_lip_dueling_replacement_top.sv
`timescale 1ns / 1ps

// RRIP replacement unit with DRRIP/LIP set dueling and per-block reuse counters.
// After reset the state memories are cleared one set a cycle, all NUM_SETS sets,
// before the first request is taken. A request then passes through accept, memory
// read, compute and write-back, and result. Whenever the update count reaches the
// programmed decay interval, the request also runs a decay sweep over all sets, with
// one read and one write of the reuse-counter memory per set, before its result is
// offered. Requests are handled one at a time.
module rrip_lip_dueling_replacement_top #(
    parameter int NUM_SETS    = rrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = rrip_pkg::NUM_WAYS_DEF,
    parameter int LEADER_SETS = rrip_pkg::LEADER_SETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode, set_index, way_index, was_hit, valid_mask, random_draw; 8 zero bits on top
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // victim_way, selector_value; 2 zero bits on top
    output logic [15:0] m_axis_tdata
);
    import rrip_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic [3:0] victim;
    logic [9:0] sel;

    rrip_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd)
    );

    rrip_dp #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LEADER_SETS(LEADER_SETS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_mode(s_axis_tdata[0]), .i_set_index(s_axis_tdata[11:1]),
        .i_way_index(s_axis_tdata[15:12]), .i_was_hit(s_axis_tdata[16]),
        .i_valid_mask(s_axis_tdata[32:17]), .i_random_draw(s_axis_tdata[39:33]),
        .o_victim_way(victim), .o_selector_value(sel)
    );

    assign m_axis_tdata = {2'b00, sel, victim};

endmodule

### bench/rrip_replacement_checker.sv
`timescale 1ns / 1ps

module rrip_replacement_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_rsp_data,
    output int          o_fail_count,
    output int          o_pending
);
    import rrip_pkg::*;

    localparam int NSETS  = NUM_SETS_DEF;
    localparam int NWAYS  = NUM_WAYS_DEF;
    localparam int LEADERS = LEADER_SETS_DEF;

    // The way sits in the low bits of the result.
    typedef struct packed {
        logic [9:0] selector_value;
        logic [3:0] victim_way;
    } t_result;

    logic [1:0]  rrv_mem   [NSETS*NWAYS];
    logic [1:0]  reuse_mem [NSETS*NWAYS];
    logic [9:0]  selector;
    logic [15:0] upd_count;
    logic [6:0]  near_pct;
    logic [15:0] decay_len;
    t_result     expected_results[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic bit drrip_leader(int s);
        return s < LEADERS;
    endfunction

    function automatic bit lip_leader(int s);
        return s >= NSETS/2 && s < NSETS/2 + LEADERS;
    endfunction

    task automatic predict_victim(int s, logic [15:0] mask, output logic [3:0] way);
        int top;
        int base;
        base = s*NWAYS;
        top  = 0;
        for (int w = 0; w < NWAYS; w++) begin
            if (!mask[w]) begin
                way = 4'(w);
                return;
            end
        end
        for (int w = 0; w < NWAYS; w++)
            if (rrv_mem[base+w] > top) top = rrv_mem[base+w];
        if (top < RRV_MAX)
            for (int w = 0; w < NWAYS; w++) rrv_mem[base+w] += 2'(RRV_MAX - top);
        way = 0;
        for (int w = NWAYS-1; w >= 0; w--)
            if (rrv_mem[base+w] == RRV_MAX) way = 4'(w);
    endtask

    task automatic predict_access(int s, int w, bit hit, logic [6:0] draw);
        int  i;
        bit  use_lip;
        i = s*NWAYS + w;
        if (hit) begin
            if (reuse_mem[i] < 3) reuse_mem[i]++;
            rrv_mem[i] = 0;
            if (drrip_leader(s)) begin
                if (selector < SEL_MAX) selector++;
            end else if (lip_leader(s)) begin
                if (selector > 0) selector--;
            end
            return;
        end
        if (reuse_mem[i] > 0) reuse_mem[i]--;
        if (reuse_mem[i] >= 2) begin
            rrv_mem[i] = 0;
        end else begin
            if (drrip_leader(s)) use_lip = 0;
            else if (lip_leader(s)) use_lip = 1;
            else use_lip = selector < SEL_MID;
            if (use_lip) rrv_mem[i] = RRV_MAX;
            else rrv_mem[i] = (draw < near_pct) ? 2'd1 : 2'd2;
        end
        reuse_mem[i] = 1;
    endtask

    always @(posedge i_clk) begin
        t_result     r;
        t_result     got;
        logic [3:0]  way;
        int          s;
        if (!i_rst_n) begin
            foreach (rrv_mem[k]) begin
                rrv_mem[k]   = RRV_MAX;
                reuse_mem[k] = 2'd1;
            end
            selector     = SEL_MID;
            upd_count    = 0;
            near_pct     = NEAR_RESET;
            decay_len    = DECAY_RESET;
            expected_results.delete();
            fail_count   = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NEAR) near_pct = i_cfg_data[6:0];
                else decay_len = i_cfg_data;
            end
            if (i_req_valid && i_req_ready) begin
                s   = int'(i_req_data[11:1]);
                way = 0;
                if (!i_req_data[0]) begin
                    predict_victim(s, i_req_data[32:17], way);
                end else begin
                    predict_access(s, int'(i_req_data[15:12]), i_req_data[16],
                                   i_req_data[39:33]);
                    upd_count++;
                    if (upd_count >= decay_len) begin
                        upd_count = 0;
                        foreach (reuse_mem[k]) if (reuse_mem[k] > 0) reuse_mem[k]--;
                    end
                end
                r.victim_way     = way;
                r.selector_value = selector;
                expected_results.push_back(r);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[13:0];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", i_rsp_data);
                end else begin
                    r = expected_results.pop_front();
                    if (got.victim_way !== r.victim_way
                        || got.selector_value !== r.selector_value) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: way exp %0d got %0d, selector exp %0d got %0d",
                                     r.victim_way, got.victim_way,
                                     r.selector_value, got.selector_value);
                    end
                end
            end
        end
    end
endmodule

### bench/tb_rrip_lip_dueling_replacement_top.sv
`timescale 1ns / 1ps

module tb_rrip_lip_dueling_replacement_top;
    import rrip_pkg::*;

    localparam int LIMIT = 6000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = CFG_NEAR;
    logic [15:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          steady_stretch = 0;
    bit          stim_done = 0;

    always #10 i_clk = ~i_clk;

    rrip_lip_dueling_replacement_top dut (.*);

    rrip_replacement_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_rsp_valid(m_axis_tvalid),
        .i_rsp_ready(m_axis_tready), .i_rsp_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result-side stalls; none during the steady stretch.
    always @(posedge i_clk)
        m_axis_tready <= steady_stretch ? 1'b1 : ($urandom_range(0, 99) >= 10);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb_rrip_lip_dueling_replacement_top NOT OK");
            $finish;
        end
    end

    // The valid flag is dropped only when the request side idles, so that a
    // request following straight on keeps it high without a second update.
    task automatic send_request(bit mode, int set_idx, int way, bit hit,
                                logic [15:0] mask, logic [6:0] draw);
        logic [47:0] d;
        while (!steady_stretch && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        d = '0;
        d[0]     = mode;
        d[11:1]  = 11'(set_idx);
        d[15:12] = 4'(way);
        d[16]    = hit;
        d[32:17] = mask;
        d[39:33] = draw;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2 * NUM_SETS_DEF + 20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a small pool of sets so that hits, refills and ageing interact.
    function automatic int pick_set();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) return $urandom_range(0, 39);
        if (k < 6) return NUM_SETS_DEF/2 + $urandom_range(0, 39);
        if (k < 9) return 100 + $urandom_range(0, 7);
        return $urandom_range(0, 2047);
    endfunction

    task automatic random_phase(int count);
        int s;
        for (int n = 0; n < count; n++) begin
            s = pick_set();
            if ($urandom_range(0, 2) == 0)
                send_request(1'b0, s, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) != 0) ? 16'hFFFF : 16'($urandom),
                             7'($urandom_range(0, 127)));
            else
                send_request(1'b1, s, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                             16'($urandom), 7'(($urandom_range(0, 9) == 0)
                             ? $urandom_range(100, 127) : $urandom_range(0, 99)));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: empty ways, full set ageing, hits and fills in both leader kinds.
        send_request(0, 0, 0, 0, 16'h0000, 0);
        send_request(0, 2047, 15, 1, 16'h7FFF, 127);
        send_request(0, 3, 0, 0, 16'hFFFF, 0);
        send_request(1, 5, 2, 1, 16'hFFFF, 0);
        send_request(1, 5, 2, 1, 16'h0, 0);
        send_request(1, 5, 2, 1, 16'h0, 0);
        send_request(1, 5, 2, 0, 16'h0, 0);
        send_request(1, 1024, 7, 1, 16'h0, 99);
        send_request(1, 1055, 15, 0, 16'h0, 127);
        send_request(1, 1056, 0, 0, 16'h0, 3);
        send_request(1, 31, 0, 0, 16'h0, 4);
        send_request(1, 32, 1, 0, 16'h0, 100);
        send_request(0, 5, 0, 0, 16'hFFFF, 0);
        send_request(0, 1055, 0, 0, 16'hFFFF, 0);
        send_request(0, 2047, 0, 0, 16'hFFFE, 0);
        write_reg(CFG_NEAR, 16'd0);
        write_reg(CFG_DECAY, 16'd1);
        random_phase(200);
        steady_stretch = 1;
        write_reg(CFG_NEAR, 16'd100);
        write_reg(CFG_DECAY, 16'd65535);
        random_phase(300);
        steady_stretch = 0;
        // Leader hits push the selector around its midpoint.
        for (int n = 0; n < 200; n++)
            send_request(1'b1, $urandom_range(0, 31), $urandom_range(0, 15), 1'b1,
                         16'h0, 7'd0);
        random_phase(200);
        for (int n = 0; n < 300; n++)
            send_request(1'b1, 1024 + $urandom_range(0, 31), $urandom_range(0, 15), 1'b1,
                         16'h0, 7'd0);
        write_reg(CFG_NEAR, 16'd127);
        write_reg(CFG_DECAY, 16'd37);
        random_phase(250);
        write_reg(CFG_NEAR, 16'd50);
        write_reg(CFG_DECAY, 16'd0);
        random_phase(40);
        write_reg(CFG_DECAY, 16'd300);
        random_phase(150);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2 * NUM_SETS_DEF + 20) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_rrip_lip_dueling_replacement_top OK");
        else
            $display("tb_rrip_lip_dueling_replacement_top NOT OK");
        $finish;
    end
endmodule
